/* rtl/core/acird_pkg.sv */
package acird_pkg;

    localparam int unsigned ByteW      = 8;
    localparam int unsigned PosW       = 5;
    localparam int unsigned CodeW      = 3;
    localparam int unsigned TempW      = 5;
    localparam int unsigned CfgIndexW  = 1;
    localparam int unsigned ResultW    = 22;
    localparam int unsigned OutTdataW  = 24;

    localparam logic [PosW-1:0]  PosSigByte  = 5'd10;
    localparam logic [PosW-1:0]  PosB13      = 5'd13;
    localparam logic [PosW-1:0]  PosB14      = 5'd14;
    localparam logic [PosW-1:0]  PosB16      = 5'd16;
    localparam logic [PosW-1:0]  PosB17      = 5'd17;
    localparam logic [PosW-1:0]  PosSumFirst = 5'd13;
    localparam logic [PosW-1:0]  PosSumLast  = 5'd25;
    localparam logic [PosW-1:0]  PosCheck    = 5'd26;
    localparam logic [PosW-1:0]  PosMax      = 5'd31;

    localparam logic [ByteW-1:0] SignatureReset = 8'hE0;
    localparam logic [ByteW-1:0] SeedReset      = 8'h06;

    localparam logic [CfgIndexW-1:0] RegSignature = 1'd0;
    localparam logic [CfgIndexW-1:0] RegSeed      = 1'd1;

    // Mode codes.
    localparam logic [CodeW-1:0] ModeAuto  = 3'd0;
    localparam logic [CodeW-1:0] ModeHeat  = 3'd1;
    localparam logic [CodeW-1:0] ModeCool  = 3'd2;
    localparam logic [CodeW-1:0] ModeDry   = 3'd3;
    localparam logic [CodeW-1:0] ModeError = 3'd4;

    // Fan, vertical and horizontal codes share auto and error values.
    localparam logic [CodeW-1:0] CodeAuto  = 3'd0;
    localparam logic [CodeW-1:0] CodeError = 3'd6;
    localparam logic [CodeW-1:0] HorCenter      = 3'd1;
    localparam logic [CodeW-1:0] HorLeft        = 3'd2;
    localparam logic [CodeW-1:0] HorLeftCenter  = 3'd3;
    localparam logic [CodeW-1:0] HorRightCenter = 3'd4;
    localparam logic [CodeW-1:0] HorRight       = 3'd5;

    // Declared from the top bit down, so recognized lands in bit 0.
    typedef struct packed {
        logic             checksum_ok;
        logic             stop_timer_active;
        logic             start_timer_active;
        logic [CodeW-1:0] horizontal_code;
        logic [CodeW-1:0] vertical_code;
        logic [CodeW-1:0] fan_code;
        logic [TempW-1:0] temperature;
        logic [CodeW-1:0] mode_code;
        logic             power_on;
        logic             recognized;
    } result_t;

endpackage

/* rtl/core/acird_decode.sv */
module acird_decode
    import acird_pkg::*;
(
    input  logic             recog,
    input  logic             sum_ok,
    input  logic [ByteW-1:0] b13,
    input  logic [ByteW-1:0] b14,
    input  logic [ByteW-1:0] b16,
    input  logic [ByteW-1:0] b17,
    output result_t          result
);

    logic [3:0]       fan_nib;
    logic [3:0]       ver_nib;
    logic [3:0]       hor_nib;
    logic [CodeW-1:0] mode_c;
    logic [CodeW-1:0] fan_c;
    logic [CodeW-1:0] ver_c;
    logic [CodeW-1:0] hor_c;

    assign fan_nib = b16[7:4];
    assign ver_nib = b16[3:0];
    assign hor_nib = b17[3:0];

    always_comb begin
        unique case (b13[7:4])
            4'h0:    mode_c = ModeAuto;
            4'h4:    mode_c = ModeHeat;
            4'h3:    mode_c = ModeCool;
            4'h2:    mode_c = ModeDry;
            default: mode_c = ModeError;
        endcase
    end

    always_comb begin
        priority if (fan_nib == 4'hA) begin
            fan_c = CodeAuto;
        end else if (fan_nib >= 4'h3 && fan_nib <= 4'h7) begin
            fan_c = CodeW'(fan_nib - 4'd2);
        end else begin
            fan_c = CodeError;
        end
    end

    always_comb begin
        priority if (ver_nib == 4'hF) begin
            ver_c = CodeAuto;
        end else if (ver_nib >= 4'h1 && ver_nib <= 4'h5) begin
            ver_c = CodeW'(ver_nib);
        end else begin
            ver_c = CodeError;
        end
    end

    always_comb begin
        unique case (hor_nib)
            4'hD:    hor_c = CodeAuto;
            4'h6:    hor_c = HorCenter;
            4'h9:    hor_c = HorLeft;
            4'hA:    hor_c = HorLeftCenter;
            4'hB:    hor_c = HorRightCenter;
            4'hC:    hor_c = HorRight;
            default: hor_c = CodeError;
        endcase
    end

    // An unrecognized frame reports all fields as zero.
    always_comb begin
        result = '0;
        if (recog) begin
            result.recognized         = 1'b1;
            result.power_on           = b13[0];
            result.mode_code          = mode_c;
            result.temperature        = {1'b1, b14[4:1]};
            result.fan_code           = fan_c;
            result.vertical_code      = ver_c;
            result.horizontal_code    = hor_c;
            result.start_timer_active = b13[1];
            result.stop_timer_active  = b13[2];
            result.checksum_ok        = sum_ok;
        end
    end

endmodule

/* rtl/core/acird_skid.sv */
module acird_skid
    import acird_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    in_acc;

    assign in_ready  = !skid_valid_reg;
    assign in_acc    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_acc;
            end
        end else if (in_acc) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end else if (in_acc) begin
                out_data_reg <= in_data;
            end
        end else if (in_acc) begin
            skid_data_reg <= in_data;
        end
    end

    // The skid stage only fills while the output register is stalled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds an item while output is empty");

endmodule

/* rtl/core/ac_ir_frame_decoder_top.sv */
// Channel   Direction  Ports                         Contents
// s_        in         s_tvalid s_tready s_tdata     one frame byte, tlast on the last byte
//                      s_tlast
// m_        out        m_tvalid m_tready m_tdata     one decoded result per frame
// cfg_      in         cfg_we cfg_index cfg_data     signature and checksum seed registers
//
// The block takes one byte per cycle while s_tready is high; a frame's result
// is registered in the output stage when its last byte is taken. Reset is
// synchronous on aresetn and clears the frame counter, the sum and the output
// stage. A two-entry output stage keeps input flowing while one result is
// stalled; s_tready drops only when both entries are full.
module ac_ir_frame_decoder_top
    import acird_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [ByteW-1:0]     s_tdata,   // [7:0] data_byte
    input  logic                 s_tlast,   // frame_end
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] recognized, [1] power_on, [4:2] mode_code, [9:5] temperature,
    // [12:10] fan_code, [15:13] vertical_code, [18:16] horizontal_code,
    // [19] start_timer_active, [20] stop_timer_active, [21] checksum_ok
    output logic [OutTdataW-1:0] m_tdata,
    input  logic                 cfg_we,
    input  logic [CfgIndexW-1:0] cfg_index,
    input  logic [ByteW-1:0]     cfg_data
);

    logic [ByteW-1:0] signature_reg;
    logic [ByteW-1:0] seed_reg;
    logic [PosW-1:0]  pos_reg;
    logic [PosW-1:0]  pos_next;
    logic [ByteW-1:0] sum_reg;
    logic [ByteW-1:0] sum_next;
    logic             sig_match_reg;
    logic [ByteW-1:0] b13_reg;
    logic [ByteW-1:0] b14_reg;
    logic [ByteW-1:0] b16_reg;
    logic [ByteW-1:0] b17_reg;

    logic    s_acc;
    logic    recog;
    logic    sum_ok;
    result_t result;
    result_t out_result;

    assign s_acc  = s_tvalid && s_tready;
    assign recog  = (pos_reg == PosCheck) && sig_match_reg;
    assign sum_ok = (pos_reg == PosCheck) && (sum_reg == s_tdata);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            signature_reg <= SignatureReset;
            seed_reg      <= SeedReset;
        end else if (cfg_we) begin
            unique case (cfg_index)
                RegSignature: signature_reg <= cfg_data;
                RegSeed:      seed_reg      <= cfg_data;
                default:      ;
            endcase
        end
    end

    always_comb begin
        if (s_tlast) begin
            pos_next = '0;
        end else if (pos_reg != PosMax) begin
            pos_next = pos_reg + PosW'(1);
        end else begin
            pos_next = pos_reg;
        end
    end

    // The seed load on the first byte and the payload add never coincide.
    always_comb begin
        sum_next = sum_reg;
        if (pos_reg == '0) begin
            sum_next = seed_reg;
        end else if (pos_reg >= PosSumFirst && pos_reg <= PosSumLast) begin
            sum_next = sum_reg + s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            sum_reg       <= '0;
            sig_match_reg <= 1'b0;
            b13_reg       <= '0;
            b14_reg       <= '0;
            b16_reg       <= '0;
            b17_reg       <= '0;
        end else if (s_acc) begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
            if (pos_reg == '0) begin
                sig_match_reg <= 1'b0;
            end else if (pos_reg == PosSigByte) begin
                sig_match_reg <= (s_tdata == signature_reg);
            end
            if (pos_reg == PosB13) b13_reg <= s_tdata;
            if (pos_reg == PosB14) b14_reg <= s_tdata;
            if (pos_reg == PosB16) b16_reg <= s_tdata;
            if (pos_reg == PosB17) b17_reg <= s_tdata;
        end
    end

    acird_decode u_decode (
        .recog  (recog),
        .sum_ok (sum_ok),
        .b13    (b13_reg),
        .b14    (b14_reg),
        .b16    (b16_reg),
        .b17    (b17_reg),
        .result (result)
    );

    acird_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid && s_tlast),
        .in_ready  (s_tready),
        .in_data   (result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tdata = {(OutTdataW - ResultW)'(0), out_result};

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_tlast) |=> (pos_reg == '0))
        else $error("byte position not cleared after the last byte");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && !s_tlast && pos_reg != PosMax) |=>
        (pos_reg == $past(pos_reg) + PosW'(1)))
        else $error("byte position did not advance");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !out_result.recognized) |-> (out_result == '0))
        else $error("unrecognized frame reports nonzero fields");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_result.recognized) |-> out_result.temperature[TempW-1])
        else $error("temperature below 16 on a recognized frame");

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
    import acird_pkg::*;

    localparam int unsigned FrameLen    = 27;
    localparam int unsigned TempBase    = 16;
    localparam int unsigned CycleLimit  = 200000;
    localparam int unsigned DrainCycles = 4;
    localparam int unsigned GapPercent  = 13;

    // Nibble tables, entry k in bits [4k+3:4k]; together they reach every code.
    localparam logic [31:0] ModeNibbles  = 32'h8F51_2340;
    localparam logic [31:0] FanNibbles   = 32'hF076_543A;
    localparam logic [31:0] VertNibbles  = 32'h9054_321F;
    localparam logic [31:0] HorNibbles   = 32'hE0CB_A96D;
    localparam logic [63:0] TempBytes    = 64'hAA55_1002_E11E_FF00;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [ByteW-1:0]     s_tdata   = '0;
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [OutTdataW-1:0] m_tdata;
    logic                 cfg_we    = 1'b0;
    logic [CfgIndexW-1:0] cfg_index = RegSignature;
    logic [ByteW-1:0]     cfg_data  = '0;

    // Decoder state as the block should hold it.
    logic [PosW-1:0]  frame_pos   = '0;
    logic [ByteW-1:0] payload_sum = '0;
    logic             sig_seen    = 1'b0;
    logic [ByteW-1:0] hold_b13    = '0;
    logic [ByteW-1:0] hold_b14    = '0;
    logic [ByteW-1:0] hold_b16    = '0;
    logic [ByteW-1:0] hold_b17    = '0;
    logic [ByteW-1:0] cfg_signature = SignatureReset;
    logic [ByteW-1:0] cfg_seed      = SeedReset;

    result_t          pending_decodes[$];
    logic [ByteW-1:0] frame_buf[$];

    bit          gaps_on = 1'b1;
    int unsigned cycle_count     = 0;
    int unsigned bytes_sent      = 0;
    int unsigned frames_sent     = 0;
    int unsigned results_checked = 0;
    int unsigned settings_used   = 0;
    int unsigned mismatches      = 0;

    ac_ir_frame_decoder_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        while (cycle_count < CycleLimit) @(posedge aclk);
        $display("FAILURE");
        $finish;
    end

    always @(posedge aclk) begin
        m_tready <= gaps_on ? ($urandom_range(99) >= GapPercent) : 1'b1;
    end

    // Advances the decoder by one byte; returns 1 when the byte closes a frame.
    function automatic bit decode_step(input logic [ByteW-1:0] b, input logic last,
                                       output result_t res);
        logic [PosW-1:0] pos;
        logic            sum_match;
        logic [3:0]      nib;
        pos       = frame_pos;
        sum_match = 1'b0;
        res       = '0;
        if (pos == '0) begin
            payload_sum = cfg_seed;
            sig_seen    = 1'b0;
        end
        if (pos == PosSigByte) sig_seen = (b == cfg_signature);
        if (pos == PosB13) hold_b13 = b;
        if (pos == PosB14) hold_b14 = b;
        if (pos == PosB16) hold_b16 = b;
        if (pos == PosB17) hold_b17 = b;
        if (pos == PosCheck) sum_match = (payload_sum == b);
        if (pos >= PosSumFirst && pos <= PosSumLast) payload_sum = payload_sum + b;
        if (!last) begin
            if (pos != PosMax) frame_pos = pos + 1'b1;
            return 1'b0;
        end
        frame_pos = '0;
        // Anything short of a full frame with the right signature decodes to all zeros.
        if (pos == PosCheck && sig_seen) begin
            res.recognized         = 1'b1;
            res.power_on           = hold_b13[0];
            res.start_timer_active = hold_b13[1];
            res.stop_timer_active  = hold_b13[2];
            case (hold_b13[7:4])
                4'h0: res.mode_code = ModeAuto;
                4'h4: res.mode_code = ModeHeat;
                4'h3: res.mode_code = ModeCool;
                4'h2: res.mode_code = ModeDry;
                default: res.mode_code = ModeError;
            endcase
            res.temperature = TempW'(hold_b14[4:1] + TempBase);
            nib = hold_b16[7:4];
            if (nib == 4'hA) res.fan_code = CodeAuto;
            else if (nib >= 4'h3 && nib <= 4'h7) res.fan_code = CodeW'(nib - 4'h2);
            else res.fan_code = CodeError;
            nib = hold_b16[3:0];
            if (nib == 4'hF) res.vertical_code = CodeAuto;
            else if (nib >= 4'h1 && nib <= 4'h5) res.vertical_code = CodeW'(nib);
            else res.vertical_code = CodeError;
            case (hold_b17[3:0])
                4'hD: res.horizontal_code = CodeAuto;
                4'h6: res.horizontal_code = HorCenter;
                4'h9: res.horizontal_code = HorLeft;
                4'hA: res.horizontal_code = HorLeftCenter;
                4'hB: res.horizontal_code = HorRightCenter;
                4'hC: res.horizontal_code = HorRight;
                default: res.horizontal_code = CodeError;
            endcase
            res.checksum_ok = sum_match;
        end
        return 1'b1;
    endfunction

    task automatic compare_field(input string field, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    always @(posedge aclk) begin : result_check
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[ResultW-1:0]);
            if (pending_decodes.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
            end else begin
                want = pending_decodes.pop_front();
                compare_field("recognized", want.recognized, got.recognized);
                compare_field("power_on", want.power_on, got.power_on);
                compare_field("mode_code", want.mode_code, got.mode_code);
                compare_field("temperature", want.temperature, got.temperature);
                compare_field("fan_code", want.fan_code, got.fan_code);
                compare_field("vertical_code", want.vertical_code, got.vertical_code);
                compare_field("horizontal_code", want.horizontal_code, got.horizontal_code);
                compare_field("start_timer_active", want.start_timer_active,
                              got.start_timer_active);
                compare_field("stop_timer_active", want.stop_timer_active,
                              got.stop_timer_active);
                compare_field("checksum_ok", want.checksum_ok, got.checksum_ok);
                compare_field("tdata padding", 0, m_tdata[OutTdataW-1:ResultW]);
                results_checked++;
            end
        end
    end

    // Every call starts and ends just after a rising edge.
    task automatic send_byte(input logic [ByteW-1:0] value, input logic last);
        result_t res;
        if (gaps_on) begin
            while ($urandom_range(99) < GapPercent) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (decode_step(value, last, res)) pending_decodes.push_back(res);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_buf[i]) send_byte(frame_buf[i], i == frame_buf.size() - 1);
        frames_sent++;
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_decodes.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
    endtask

    task automatic set_registers(input logic [ByteW-1:0] signature,
                                 input logic [ByteW-1:0] seed);
        cfg_we    <= 1'b1;
        cfg_index <= RegSignature;
        cfg_data  <= signature;
        @(posedge aclk);
        cfg_index <= RegSeed;
        cfg_data  <= seed;
        @(posedge aclk);
        cfg_we        <= 1'b0;
        cfg_signature = signature;
        cfg_seed      = seed;
        settings_used++;
        @(posedge aclk);
    endtask

    // Builds a full-length frame around the four decoded bytes.
    function automatic void make_frame(input logic [ByteW-1:0] b13, input logic [ByteW-1:0] b14,
                                       input logic [ByteW-1:0] b16, input logic [ByteW-1:0] b17,
                                       input bit sig_good, input bit sum_good);
        logic [ByteW-1:0] sum;
        frame_buf.delete();
        repeat (FrameLen) frame_buf.push_back(ByteW'($urandom));
        frame_buf[PosSigByte] = sig_good ? cfg_signature
                                         : cfg_signature ^ ByteW'($urandom_range(1, 255));
        frame_buf[PosB13] = b13;
        frame_buf[PosB14] = b14;
        frame_buf[PosB16] = b16;
        frame_buf[PosB17] = b17;
        sum = cfg_seed;
        for (int i = PosSumFirst; i <= PosSumLast; i++) sum = sum + frame_buf[i];
        frame_buf[PosCheck] = sum_good ? sum : sum ^ ByteW'($urandom_range(1, 255));
    endfunction

    function automatic logic [3:0] pick_nibble(input logic [31:0] tbl);
        int unsigned k;
        k = $urandom_range(7);
        return tbl[4*k +: 4];
    endfunction

    function automatic void make_noise(input int unsigned len);
        frame_buf.delete();
        repeat (len) frame_buf.push_back(ByteW'($urandom));
    endfunction

    task automatic test_directed_frames();
        logic [ByteW-1:0] b13;
        logic [ByteW-1:0] b16;
        logic [ByteW-1:0] b17;
        for (int k = 0; k < 8; k++) begin
            b13 = {ModeNibbles[4*k +: 4], ~k[0], k[2:0]};
            b16 = {FanNibbles[4*k +: 4], VertNibbles[4*k +: 4]};
            b17 = {4'($urandom), HorNibbles[4*k +: 4]};
            make_frame(b13, TempBytes[8*k +: 8], b16, b17, 1'b1, k != 7);
            send_frame();
        end
        make_frame(8'h01, 8'h1E, 8'hAF, 8'h0D, 1'b0, 1'b1);
        send_frame();
        make_noise(1);
        frame_buf[0] = 8'hFF;
        send_frame();
        make_noise(1);
        frame_buf[0] = 8'h00;
        send_frame();
        // One byte short, one byte long, and long enough for the position to saturate.
        make_frame(8'h41, 8'h0A, 8'h53, 8'h06, 1'b1, 1'b1);
        void'(frame_buf.pop_back());
        send_frame();
        make_frame(8'h41, 8'h0A, 8'h53, 8'h06, 1'b1, 1'b1);
        frame_buf.push_back(8'h00);
        send_frame();
        make_frame(8'h41, 8'h0A, 8'h53, 8'h06, 1'b1, 1'b1);
        repeat (13) frame_buf.push_back(ByteW'($urandom));
        send_frame();
        make_noise(FrameLen);
        foreach (frame_buf[i]) frame_buf[i] = 8'hFF;
        send_frame();
        make_frame(8'h37, 8'hFF, 8'h7F, 8'hFC, 1'b1, 1'b1);
        send_frame();
        wait_for_results();
    endtask

    task automatic test_register_settings();
        logic [15:0] sweep [4];
        sweep = '{16'h0000, 16'hFFFF, 16'h5AA5, 16'hE006};
        for (int s = 0; s < 4; s++) begin
            set_registers(sweep[s][15:8], sweep[s][7:0]);
            make_frame(ByteW'($urandom), ByteW'($urandom), ByteW'($urandom),
                       ByteW'($urandom), 1'b1, 1'b1);
            send_frame();
            make_frame(8'h20, 8'h00, 8'hA1, 8'h09, 1'b1, 1'b0);
            send_frame();
            make_frame(8'h30, 8'h10, 8'h35, 8'h0B, 1'b0, 1'b1);
            send_frame();
            wait_for_results();
        end
    endtask

    // Back-to-back frames with neither side idling.
    task automatic test_burst_without_gaps();
        gaps_on = 1'b0;
        repeat (4) begin
            make_frame(ByteW'($urandom), ByteW'($urandom), ByteW'($urandom),
                       ByteW'($urandom), 1'b1, 1'b1);
            send_frame();
        end
        repeat (12) begin
            make_noise(1);
            send_frame();
        end
        wait_for_results();
        gaps_on = 1'b1;
    endtask

    task automatic send_random_frame();
        int unsigned      pick;
        logic [ByteW-1:0] b13;
        logic [ByteW-1:0] b16;
        logic [ByteW-1:0] b17;
        pick = $urandom_range(99);
        b13  = $urandom_range(1) ? {pick_nibble(ModeNibbles), 4'($urandom)} : ByteW'($urandom);
        b16  = ByteW'($urandom);
        if ($urandom_range(1)) b16[7:4] = pick_nibble(FanNibbles);
        if ($urandom_range(1)) b16[3:0] = pick_nibble(VertNibbles);
        b17  = ByteW'($urandom);
        if ($urandom_range(3) != 0) b17[3:0] = pick_nibble(HorNibbles);
        if (pick < 80) begin
            make_frame(b13, ByteW'($urandom), b16, b17,
                       $urandom_range(99) < 92, $urandom_range(99) < 85);
            // Some well-formed frames come a byte or two off the right length.
            if (pick >= 70) begin
                if ($urandom_range(1)) begin
                    repeat ($urandom_range(1, 2)) void'(frame_buf.pop_back());
                end else begin
                    repeat ($urandom_range(1, 2)) frame_buf.push_back(ByteW'($urandom));
                end
            end
        end else if (pick < 92) begin
            make_noise($urandom_range(1, 12));
        end else begin
            make_noise($urandom_range(13, 40));
        end
        send_frame();
    endtask

    task automatic test_random_frames();
        int unsigned start_bytes;
        int unsigned frames;
        start_bytes = bytes_sent;
        frames      = 0;
        while ((bytes_sent - start_bytes) < 260 || frames < 10) begin
            if (frames % 10 == 9) begin
                wait_for_results();
                set_registers(ByteW'($urandom), ByteW'($urandom));
            end else if ($urandom_range(99) < 5) begin
                wait_for_results();
            end
            send_random_frame();
            frames++;
        end
        wait_for_results();
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_frames();
        test_register_settings();
        test_burst_without_gaps();
        test_random_frames();
        wait_for_results();
        repeat (8) @(posedge aclk);
        $display("Sent %0d frames in %0d bytes and checked %0d decoded results under %0d settings.",
                 frames_sent, bytes_sent, results_checked, settings_used);
        $display("Frames were well-formed, off-signature, bad-checksum, short, long and noise.");
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
